FILE: rtl/ethernet_header_classifier_unit_macros.svh
// ----------------------------------------------------------------------------
// ethernet header classifier assertion macros
// shared concurrent assertion forms, clocked on the rising edge, reset low
// ----------------------------------------------------------------------------
`ifndef ETHERNET_HEADER_CLASSIFIER_UNIT_MACROS_SVH
`define ETHERNET_HEADER_CLASSIFIER_UNIT_MACROS_SVH

// same-cycle implication
`define EHC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ehc assertion failed");

// next-cycle implication
`define EHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ehc assertion failed");

`endif

FILE: rtl/ehc_pkg.sv
// ----------------------------------------------------------------------------
// ehc_pkg
// shared types and constants of the ethernet header classifier
// ----------------------------------------------------------------------------
package ehc_pkg;

    localparam int HEADER_BYTES = 42;
    localparam int COUNT_W      = 6;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;

    localparam logic [COUNT_W-1:0] LEN_ETH  = 6'd14;
    localparam logic [COUNT_W-1:0] LEN_IPV4 = 6'd34;
    localparam logic [COUNT_W-1:0] LEN_ARP  = 6'd42;
    localparam logic [COUNT_W-1:0] LEN_UDP  = 6'd42;
    localparam logic [COUNT_W-1:0] LEN_TCP  = 6'd54;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;

    localparam int SUMMARY_BITS = 233;
    localparam int TDATA_W      = ((SUMMARY_BITS + 7) / 8) * 8;
    localparam int TUSER_W      = 2;

    typedef enum logic [1:0] {
        CLASS_RUNT = 2'd0,
        CLASS_ETH  = 2'd1,
        CLASS_IPV4 = 2'd2,
        CLASS_ARP  = 2'd3
    } frame_class_t;

    typedef logic [7:0] hdr_byte_t;
    typedef hdr_byte_t [HEADER_BYTES-1:0] hdr_store_t;

    // frame end marker handed from capture to classify
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] len;
    } frame_end_t;

    typedef struct packed {
        frame_class_t frame_class;
        logic [47:0]  dst_mac;
        logic [47:0]  src_mac;
        logic [15:0]  ether_type;
        logic [7:0]   ip_proto;
        logic [31:0]  src_ip;
        logic [31:0]  dst_ip;
        logic         ports_valid;
        logic [15:0]  l4_sport;
        logic [15:0]  l4_dport;
        logic [15:0]  arp_op;
    } summary_t;

endpackage

FILE: rtl/ehc_capture.sv
// ----------------------------------------------------------------------------
// ehc_capture
// byte counter, header byte store and end-of-frame marker
// ----------------------------------------------------------------------------
`include "ethernet_header_classifier_unit_macros.svh"

module ehc_capture
    import ehc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       out_free,
    output hdr_store_t store,
    output frame_end_t frame_end
);

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] count_inc;
    hdr_store_t         store_reg;
    frame_end_t         end_reg;
    frame_end_t         end_next;
    logic               accept;
    logic               advance;

    // a pending frame end blocks input only while the result slot is full
    assign in_ready = !end_reg.valid || out_free;
    assign accept   = in_valid && in_ready;
    assign advance  = end_reg.valid && out_free;

    assign count_inc = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        end_next   = end_reg;
        if (advance)
        begin
            end_next.valid = 1'b0;
        end
        if (accept)
        begin
            count_next = last_byte ? '0 : count_inc;
            if (last_byte)
            begin
                end_next.valid = 1'b1;
                end_next.len   = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            end_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            end_reg   <= end_next;
        end
    end

    // bytes past the header are dropped
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < HEADER_BYTES; i++)
        begin
            if (accept && count_reg == COUNT_W'(i))
            begin
                store_reg[i] <= data_byte;
            end
        end
    end

    assign store     = store_reg;
    assign frame_end = end_reg;

    `EHC_ASSERT_NEXT(a_last_clears_count, clk, rst_n, accept && last_byte, count_reg == '0)
    `EHC_ASSERT_IMPL(a_stall_holds_input, clk, rst_n, end_reg.valid && !out_free, !in_ready)
    `EHC_ASSERT_IMPL(a_end_len_nonzero, clk, rst_n, end_reg.valid, end_reg.len != '0)

endmodule

FILE: rtl/ehc_classify.sv
// ----------------------------------------------------------------------------
// ehc_classify
// decodes the stored header into the frame summary
// ----------------------------------------------------------------------------
module ehc_classify
    import ehc_pkg::*;
(
    input  hdr_store_t         store,
    input  logic [COUNT_W-1:0] len,
    output summary_t           summary
);

    logic [15:0] etype;
    logic [7:0]  proto;

    assign etype = {store[12], store[13]};
    assign proto = store[23];

    always_comb
    begin
        summary = '0;
        summary.frame_class = CLASS_RUNT;
        if (len >= LEN_ETH)
        begin
            summary.frame_class = CLASS_ETH;
            summary.dst_mac     = {store[0], store[1], store[2],
                                   store[3], store[4], store[5]};
            summary.src_mac     = {store[6], store[7], store[8],
                                   store[9], store[10], store[11]};
            summary.ether_type  = etype;
            if (etype == ETYPE_IPV4 && len >= LEN_IPV4)
            begin
                summary.frame_class = CLASS_IPV4;
                summary.ip_proto    = proto;
                summary.src_ip      = {store[26], store[27], store[28], store[29]};
                summary.dst_ip      = {store[30], store[31], store[32], store[33]};
                // ports sit right after a minimal ip header, options ignored
                if ((proto == PROTO_TCP && len >= LEN_TCP) ||
                    (proto == PROTO_UDP && len >= LEN_UDP))
                begin
                    summary.ports_valid = 1'b1;
                    summary.l4_sport    = {store[34], store[35]};
                    summary.l4_dport    = {store[36], store[37]};
                end
            end
            else if (etype == ETYPE_ARP && len >= LEN_ARP)
            begin
                summary.frame_class = CLASS_ARP;
                summary.src_ip      = {store[28], store[29], store[30], store[31]};
                summary.dst_ip      = {store[38], store[39], store[40], store[41]};
                summary.arp_op      = {store[20], store[21]};
            end
        end
    end

endmodule

FILE: rtl/ethernet_header_classifier_unit.sv
// ----------------------------------------------------------------------------
// ethernet_header_classifier_unit
// classifies ethernet frames and reports mac, ipv4, arp and port fields
//
//   channel  dir  word                         per word
//   s_axis   in   one frame byte, tlast = end  every cycle unless stalled
//   m_axis   out  one summary per frame        from the result register
//
// one byte is taken per cycle unless input stalls; the frame end marker registers the
// last byte, then the summary of the frame is loaded into the result register
// the byte store and frame end marker feed a single decode stage into the result register
// reset clears the counter, the frame end marker and the result valid
// input stalls only when a frame end waits and the result register is held
// ----------------------------------------------------------------------------
`include "ethernet_header_classifier_unit_macros.svh"

module ethernet_header_classifier_unit
    import ehc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] data_byte
    input  logic               s_axis_tlast,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [47:0] dst_mac, [95:48] src_mac, [111:96] ether_type, [119:112] ip_proto,
    // [151:120] src_ip, [183:152] dst_ip, [184] ports_valid,
    // [200:185] l4_sport, [216:201] l4_dport, [232:217] arp_op, rest zero
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic [TUSER_W-1:0] m_axis_tuser    // [1:0] frame_class
);

    hdr_store_t store;
    frame_end_t frame_end;
    summary_t   summary;
    summary_t   result_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       load;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign load     = frame_end.valid && out_free;

    ehc_capture u_capture (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .data_byte (s_axis_tdata),
        .last_byte (s_axis_tlast),
        .out_free  (out_free),
        .store     (store),
        .frame_end (frame_end)
    );

    ehc_classify u_classify (
        .store   (store),
        .len     (frame_end.len),
        .summary (summary)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= summary;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = result_reg.frame_class;
    assign m_axis_tdata  = {{(TDATA_W - SUMMARY_BITS){1'b0}},
                            result_reg.arp_op, result_reg.l4_dport, result_reg.l4_sport,
                            result_reg.ports_valid, result_reg.dst_ip,
                            result_reg.src_ip, result_reg.ip_proto,
                            result_reg.ether_type, result_reg.src_mac,
                            result_reg.dst_mac};

    `EHC_ASSERT_IMPL(a_runt_all_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser == CLASS_RUNT, m_axis_tdata == '0)
    `EHC_ASSERT_IMPL(a_ports_need_ipv4, clk, rst_n, m_axis_tvalid && result_reg.ports_valid, m_axis_tuser == CLASS_IPV4)
    `EHC_ASSERT_IMPL(a_arp_op_needs_arp, clk, rst_n, m_axis_tvalid && result_reg.arp_op != '0, m_axis_tuser == CLASS_ARP)

endmodule
